FILE: rtl/rmg_pkg.sv
// ----------------------------------------------------------------------------
// rmg_pkg
// shared types, constants and the elaboration-time sine table function
// ----------------------------------------------------------------------------
package rmg_pkg;

  localparam int MAX_SIDES_DEF = 256;
  localparam int SINE_BITS_DEF = 16;

  localparam longint unsigned PI_Q30    = 64'd3373259426;
  localparam longint unsigned SQRT2_Q30 = 64'd1518500250;

  localparam int SIDE_W = 9;
  localparam int IDX_W  = 9;
  localparam int POS_W  = 17;
  localparam int TEX_W  = 17;
  localparam int RAD_W  = 16;
  localparam int DEG_W  = 9;

  typedef enum logic [2:0] {
    PH_BASE = 3'd0,
    PH_TOP  = 3'd1,
    PH_BFAN = 3'd2,
    PH_SIDE = 3'd3,
    PH_TFAN = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_POLY    = 2'd0,
    KIND_PRISM   = 2'd1,
    KIND_PYRAMID = 2'd2,
    KIND_SPARE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_SHAPE_KIND = 2'd0,
    REG_SIDE_COUNT = 2'd1,
    REG_RADIUS     = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

  // sine of an integer degree 0..90, rounded to sb-1 fraction bits;
  // only ever called with constant arguments
  // taylor series up to x^17, each term truncated
  function automatic longint unsigned sine_q1(int r, int sb);
    longint unsigned x, x2, sum, term;
    x    = (longint'(r) * PI_Q30 + 64'd90) / 64'd180;
    x2   = (x * x) >> 30;
    sum  = x;
    term = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + term;
    return ((sum << (sb - 1)) + (64'd1 << 29)) >> 30;
  endfunction

endpackage

FILE: rtl/rmg_sine.sv
// ----------------------------------------------------------------------------
// rmg_sine
// quadrant folding and quarter-wave sine table, magnitude and sign out
// ----------------------------------------------------------------------------
module rmg_sine import rmg_pkg::*; #(
  parameter int SINE_BITS = SINE_BITS_DEF
) (
  input  logic [DEG_W-1:0]     deg,
  output logic [SINE_BITS-1:0] mag,
  output logic                 neg
);

  logic [SINE_BITS-1:0] tbl [0:90];
  logic [DEG_W-1:0]     d;
  logic [DEG_W-1:0]     r;
  logic [1:0]           q;

  for (genvar g = 0; g <= 90; g++) begin : g_tbl
    assign tbl[g] = SINE_BITS'(sine_q1(g, SINE_BITS));
  end

  always_comb begin
    d = (deg >= DEG_W'(360)) ? deg - DEG_W'(360) : deg;
    if (d >= DEG_W'(270)) begin
      q = 2'd3;
      r = d - DEG_W'(270);
    end else if (d >= DEG_W'(180)) begin
      q = 2'd2;
      r = d - DEG_W'(180);
    end else if (d >= DEG_W'(90)) begin
      q = 2'd1;
      r = d - DEG_W'(90);
    end else begin
      q = 2'd0;
      r = d;
    end
    mag = q[0] ? tbl[7'(DEG_W'(90) - r)] : tbl[7'(r)];
    neg = q[1] && (mag != '0);
  end

endmodule

FILE: rtl/rmg_vertex.sv
// ----------------------------------------------------------------------------
// rmg_vertex
// vertex position and texture coordinates from angle and radius
// ----------------------------------------------------------------------------
module rmg_vertex import rmg_pkg::*; #(
  parameter int SINE_BITS = SINE_BITS_DEF
) (
  input  logic [DEG_W-1:0] angle,
  input  logic [RAD_W-1:0] radius,
  input  logic             square,
  output logic [POS_W-1:0] pos_x,
  output logic [POS_W-1:0] pos_z,
  output logic [TEX_W-1:0] tex_u,
  output logic [TEX_W-1:0] tex_v
);

  localparam int PW = RAD_W + SINE_BITS;
  localparam int TW = SINE_BITS + 31;

  logic [SINE_BITS-1:0] s_mag, c_mag;
  logic                 s_neg, c_neg;
  logic [DEG_W-1:0]     cos_deg;
  logic [30:0]          fac;

  assign cos_deg = angle + DEG_W'(90);
  assign fac     = square ? 31'(SQRT2_Q30) : 31'(64'd1 << 30);

  rmg_sine #(.SINE_BITS(SINE_BITS)) u_sin (.deg(angle),   .mag(s_mag), .neg(s_neg));
  rmg_sine #(.SINE_BITS(SINE_BITS)) u_cos (.deg(cos_deg), .mag(c_mag), .neg(c_neg));

  function automatic logic [POS_W-1:0] pos_f(logic [RAD_W-1:0] rad,
                                             logic [SINE_BITS-1:0] m, logic n);
    logic [PW-1:0]    p;
    logic [POS_W-1:0] v;
    p = PW'(rad) * PW'(m) + (PW'(1) << (SINE_BITS - 2));
    v = POS_W'(p >> (SINE_BITS - 1));
    return n ? (POS_W'(0) - v) : v;
  endfunction

  function automatic logic [TEX_W-1:0] tex_f(logic [SINE_BITS-1:0] m, logic n,
                                             logic [30:0] f);
    logic [TW-1:0]    p;
    logic [TW-1:0]    rr;
    logic [TEX_W-1:0] r;
    p  = TW'(m) * TW'(f) + (TW'(1) << (SINE_BITS + 13));
    rr = p >> (SINE_BITS + 14);
    r  = (rr > TW'(32768)) ? TEX_W'(32768) : TEX_W'(rr);
    return n ? (TEX_W'(32768) - r) : (TEX_W'(32768) + r);
  endfunction

  assign pos_x = pos_f(radius, s_mag, s_neg);
  assign pos_z = pos_f(radius, c_mag, c_neg);
  assign tex_u = tex_f(s_mag, s_neg, fac);
  assign tex_v = tex_f(c_mag, c_neg, fac);

endmodule

FILE: rtl/rmg_div.sv
// ----------------------------------------------------------------------------
// rmg_div
// restoring divider for the per-vertex angle step 360 / n, one bit a cycle
// ----------------------------------------------------------------------------
module rmg_div import rmg_pkg::*; #(
  parameter int NW = SIDE_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] n,
  output logic          busy,
  output logic [8:0]    quo,
  output logic [NW-1:0] rem
);

  localparam logic [8:0] DIVIDEND = 9'd360;

  logic [3:0]    cnt_r, cnt_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [8:0]    quo_r, quo_nxt;
  logic [NW:0]   rem_r, rem_nxt;
  logic [NW:0]   trial;

  always_comb begin
    cnt_nxt = cnt_r;
    n_nxt   = n_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    trial   = {rem_r[NW-1:0], DIVIDEND[cnt_r - 4'd1]};
    if (start) begin
      cnt_nxt = 4'd9;
      n_nxt   = n;
      quo_nxt = '0;
      rem_nxt = '0;
    end else if (cnt_r != 4'd0) begin
      cnt_nxt = cnt_r - 4'd1;
      if (trial >= {1'b0, n_r}) begin
        rem_nxt = trial - {1'b0, n_r};
        quo_nxt = {quo_r[7:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[7:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      n_r   <= NW'(4);
      quo_r <= 9'd90;
      rem_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      n_r   <= n_nxt;
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = (cnt_r != 4'd0);
  assign quo  = quo_r;
  assign rem  = rem_r[NW-1:0];

endmodule

FILE: rtl/regular_mesh_generator_unit.sv
// ----------------------------------------------------------------------------
// regular_mesh_generator_unit
// streams the elements of a regular polygon, prism or pyramid mesh
// ----------------------------------------------------------------------------
// usage:
//   each word taken on the in_ channel yields exactly one word on the out_
//   channel: the next mesh element (base vertices, top vertices or apex,
//   then base fan, side and top fan triangles). in_tdata[0] set restarts
//   the mesh at its first element. out_tuser is 1 for a vertex, out_tlast
//   marks the final element; the element after it is the first one again.
//   cfg_ writes set shape kind, side count and radius and restart the mesh.
// flow:
//   one word per cycle while the divider is idle and no cfg_ write is
//   offered; the result is registered in the cycle after acceptance. the
//   element is formed from counters, quarter-wave sine lookups and
//   multiplies by the radius between the state and the output register.
//   after a side count write, in_tready is low while the 360/n divider runs.
// reset:
//   shape polygon, 4 sides, radius 256, mesh at its first element.
// stall:
//   a held output word keeps in_tready low unless out_tready is high, so no
//   word is lost or repeated.
// ----------------------------------------------------------------------------
module regular_mesh_generator_unit import rmg_pkg::*; #(
  parameter int MAX_SIDES = MAX_SIDES_DEF,
  parameter int SINE_BITS = SINE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // input channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [0] restart, [7:1] zero
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x[16:0] pos_y[33:17] pos_z[50:34] tex_u[67:51] tex_v[84:68]
  // corner_a[93:85] corner_b[102:94] corner_c[111:103]
  output logic [111:0] out_tdata,
  output logic         out_tuser,  // is_vertex
  output logic         out_tlast,  // last_of_shape
  // configuration write channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  // counter width holds both the 9-bit register and the clamped side count
  localparam int CW = ($clog2(MAX_SIDES + 1) > SIDE_W) ? $clog2(MAX_SIDES + 1) : SIDE_W;
  localparam int EW = CW + 2;

  // config registers
  logic [1:0]        kind_r;
  logic [SIDE_W-1:0] sides_r;
  logic [RAD_W-1:0]  radius_r;

  // mesh walk state
  phase_t        phase_r, phase_nxt;
  logic [CW-1:0] ec_r, ec_nxt;
  logic [CW-1:0] stride_r, stride_nxt;
  logic          half_r, half_nxt;
  logic [8:0]    qacc_r, qacc_nxt;     // floor(360*i/n)
  logic [CW-1:0] racc_r, racc_nxt;     // 360*i mod n

  // output register
  logic         ovld_r;
  logic [111:0] odata_r, odata_nxt;
  logic         ouser_r, ouser_nxt;
  logic         olast_r, olast_nxt;

  logic in_acc, cfg_acc, div_busy, div_start;
  logic [8:0]    step_q;
  logic [CW-1:0] step_r;
  logic [CW-1:0] n_eff, n_new;
  logic [CW-1:0] cfg_sides;
  kind_t         kind_eff;

  // working copies after restart
  phase_t        ph;
  logic [CW-1:0] ec, m;
  logic          sh;
  logic [8:0]    qa;
  logic [CW-1:0] ra;

  logic [DEG_W-1:0] angle;
  logic [POS_W-1:0] vx, vz;
  logic [TEX_W-1:0] vu, vv;
  logic [POS_W-1:0] height;
  logic [RAD_W+31-1:0] hprod;

  logic             f_vert, f_geom, f_last;
  logic [POS_W-1:0] f_y;
  logic [IDX_W-1:0] f_a, f_b, f_c;

  logic [EW-1:0] s2, fc, m2, ec1, nxi;
  logic [CW:0]   rsum;
  logic          fan_wrap, fan_done;
  logic [CW-1:0] off;

  // clamp a side count into 3..MAX_SIDES
  function automatic logic [CW-1:0] clamp_n(logic [CW-1:0] v);
    if (v < CW'(3)) return CW'(3);
    else if (v > CW'(MAX_SIDES)) return CW'(MAX_SIDES);
    else return v;
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid;
  assign in_tready = (!ovld_r || out_tready) && !div_busy && !cfg_valid;
  assign in_acc    = in_tvalid && in_tready;

  assign cfg_sides = CW'(cfg_data[SIDE_W-1:0]);
  assign n_new     = clamp_n(cfg_sides);
  assign n_eff     = clamp_n(CW'(sides_r));
  assign kind_eff  = (kind_r == KIND_SPARE) ? KIND_POLY : kind_t'(kind_r);
  assign div_start = cfg_acc && (cfg_index == REG_SIDE_COUNT);

  rmg_div #(.NW(CW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .n     (n_new),
    .busy  (div_busy),
    .quo   (step_q),
    .rem   (step_r)
  );

  // apex / top height: round(radius * sqrt2)
  assign hprod  = (RAD_W+31)'(radius_r) * (RAD_W+31)'(SQRT2_Q30) + ((RAD_W+31)'(1) << 29);
  assign height = POS_W'(hprod >> 30);

  assign angle = qa + DEG_W'(45);

  rmg_vertex #(.SINE_BITS(SINE_BITS)) u_vertex (
    .angle  (angle),
    .radius (radius_r),
    .square (n_eff == CW'(4)),
    .pos_x  (vx),
    .pos_z  (vz),
    .tex_u  (vu),
    .tex_v  (vv)
  );

  // element sequencer
  always_comb begin
    ph = phase_r;
    ec = ec_r;
    m  = stride_r;
    sh = half_r;
    qa = qacc_r;
    ra = racc_r;
    if (in_tdata[0]) begin
      ph = PH_BASE;
      ec = '0;
      m  = CW'(1);
      sh = 1'b0;
      qa = '0;
      ra = '0;
    end

    phase_nxt  = ph;
    ec_nxt     = ec;
    stride_nxt = m;
    half_nxt   = sh;
    qacc_nxt   = qa;
    racc_nxt   = ra;

    f_vert = 1'b0;
    f_geom = 1'b0;
    f_last = 1'b0;
    f_y    = '0;
    f_a    = '0;
    f_b    = '0;
    f_c    = '0;

    // angle step to the next vertex
    rsum = {1'b0, ra} + {1'b0, step_r};
    ec1  = EW'(ec) + EW'(1);

    // fan step
    off      = (ph == PH_TFAN) ? n_eff : '0;
    s2       = EW'(ec) + (EW'(m) << 1);
    fc       = (s2 >= EW'(n_eff)) ? '0 : s2;
    m2       = EW'(m) << 1;
    fan_wrap = (s2 + EW'(m)) >= EW'(n_eff);
    fan_done = fan_wrap && ((m2 << 1) >= EW'(n_eff));
    nxi      = (ec1 >= EW'(n_eff)) ? '0 : ec1;

    case (ph)
      PH_BASE, PH_TOP: begin
        if (ph == PH_TOP && kind_eff == KIND_PYRAMID) begin
          // apex
          f_vert    = 1'b1;
          f_y       = height;
          ec_nxt    = '0;
          phase_nxt = PH_BFAN;
        end else begin
          f_vert = 1'b1;
          f_geom = 1'b1;
          f_y    = (ph == PH_TOP) ? height : '0;
          if (ec1 >= EW'(n_eff)) begin
            ec_nxt   = '0;
            qacc_nxt = '0;
            racc_nxt = '0;
            if (ph == PH_TOP || kind_eff == KIND_POLY) phase_nxt = PH_BFAN;
            else phase_nxt = PH_TOP;
          end else begin
            ec_nxt = CW'(ec1);
            if (rsum >= {1'b0, n_eff}) begin
              racc_nxt = CW'(rsum - {1'b0, n_eff});
              qacc_nxt = qa + step_q + 9'd1;
            end else begin
              racc_nxt = CW'(rsum);
              qacc_nxt = qa + step_q;
            end
          end
        end
      end
      PH_SIDE: begin
        if (kind_eff == KIND_PYRAMID) begin
          f_a = IDX_W'(ec);
          f_b = IDX_W'(nxi);
          f_c = IDX_W'(n_eff);
          ec_nxt = CW'(ec1);
        end else if (!sh) begin
          f_a = IDX_W'(ec);
          f_b = IDX_W'(nxi);
          f_c = IDX_W'(EW'(ec) + EW'(n_eff));
          half_nxt = 1'b1;
        end else begin
          f_a = IDX_W'(EW'(ec) + EW'(n_eff));
          f_b = IDX_W'(nxi + EW'(n_eff));
          f_c = IDX_W'(nxi);
          half_nxt = 1'b0;
          ec_nxt = CW'(ec1);
        end
        if ((kind_eff == KIND_PYRAMID || sh) && ec1 >= EW'(n_eff)) begin
          ec_nxt = '0;
          if (kind_eff == KIND_PYRAMID) begin
            f_last    = 1'b1;
            phase_nxt = PH_BASE;
            stride_nxt = CW'(1);
            half_nxt  = 1'b0;
          end else begin
            phase_nxt = PH_TFAN;
          end
        end
      end
      PH_BFAN, PH_TFAN: begin
        f_a = IDX_W'(EW'(ec) + EW'(off));
        f_b = IDX_W'(EW'(ec) + EW'(m) + EW'(off));
        f_c = IDX_W'(fc + EW'(off));
        if (fan_done) begin
          ec_nxt     = '0;
          stride_nxt = CW'(1);
          if (ph == PH_TFAN || kind_eff == KIND_POLY) begin
            f_last    = 1'b1;
            phase_nxt = PH_BASE;
            half_nxt  = 1'b0;
            qacc_nxt  = '0;
            racc_nxt  = '0;
          end else begin
            phase_nxt = PH_SIDE;
          end
        end else if (fan_wrap) begin
          ec_nxt     = '0;
          stride_nxt = CW'(m2);
        end else begin
          ec_nxt = CW'(s2);
        end
      end
      default: begin
        phase_nxt  = PH_BASE;
        ec_nxt     = '0;
        stride_nxt = CW'(1);
        half_nxt   = 1'b0;
        qacc_nxt   = '0;
        racc_nxt   = '0;
      end
    endcase

    ouser_nxt = f_vert;
    olast_nxt = f_last;
    odata_nxt = {f_c, f_b, f_a,
                 f_geom ? vv : TEX_W'(0), f_geom ? vu : TEX_W'(0),
                 f_geom ? vz : POS_W'(0), f_y, f_geom ? vx : POS_W'(0)};
  end

  // config registers and mesh state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= KIND_POLY;
      sides_r  <= SIDE_W'(4);
      radius_r <= RAD_W'(256);
      phase_r  <= PH_BASE;
      ec_r     <= '0;
      stride_r <= CW'(1);
      half_r   <= 1'b0;
      qacc_r   <= '0;
      racc_r   <= '0;
    end else if (cfg_acc) begin
      case (cfg_index)
        REG_SHAPE_KIND: kind_r   <= cfg_data[1:0];
        REG_SIDE_COUNT: sides_r  <= cfg_data[SIDE_W-1:0];
        REG_RADIUS:     radius_r <= cfg_data;
        default: ;
      endcase
      if (cfg_index != REG_NONE) begin
        phase_r  <= PH_BASE;
        ec_r     <= '0;
        stride_r <= CW'(1);
        half_r   <= 1'b0;
        qacc_r   <= '0;
        racc_r   <= '0;
      end
    end else if (in_acc) begin
      phase_r  <= phase_nxt;
      ec_r     <= ec_nxt;
      stride_r <= stride_nxt;
      half_r   <= half_nxt;
      qacc_r   <= qacc_nxt;
      racc_r   <= racc_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (in_acc) begin
      ovld_r <= 1'b1;
    end else if (out_tready) begin
      ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      odata_r <= odata_nxt;
      ouser_r <= ouser_nxt;
      olast_r <= olast_nxt;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;

`ifndef SYNTHESIS
  // no item enters while the angle step divider is running
  a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !div_busy) else $error("item accepted while divider busy");

  // every accepted item shows up as a result on the next cycle
  a_acc_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_tvalid) else $error("accepted item produced no result");

  // a restart always yields a base vertex
  a_restart_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tdata[0] |=> out_tuser && out_tdata[33:17] == '0)
    else $error("restart did not yield base vertex");

  // triangles carry no geometry
  a_tri_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[84:0] == '0)
    else $error("triangle with nonzero geometry");
`endif

endmodule
